FILE: hdl/tmas_pkg.sv
// shared types and constants of the tile map attribute store
package tmas_pkg;

    localparam int MAP_WIDTH   = 32;
    localparam int MAP_HEIGHT  = 30;
    localparam int TILE_DEPTH  = MAP_WIDTH * MAP_HEIGHT;
    localparam int ATTR_STRIDE = (MAP_WIDTH + 3) / 4;
    localparam int ATTR_ROWS   = (MAP_HEIGHT + 3) / 4;
    localparam int ATTR_DEPTH  = ATTR_STRIDE * ATTR_ROWS;
    localparam int TILE_AW     = $clog2(TILE_DEPTH);
    localparam int ATTR_AW     = $clog2(ATTR_DEPTH);
    localparam int COORD_W     = 6;
    localparam int DATA_W      = 8;
    localparam int OP_W        = 3;
    // tile byte plus collision bit in the msb
    localparam int CELL_W      = DATA_W + 1;
    localparam int FIELD_W     = 2;
    localparam int FIELDS      = DATA_W / FIELD_W;
    localparam int SOLID_MIN   = 128;

    typedef enum logic [OP_W-1:0] {
        OP_RD_TILE  = 3'd0,
        OP_WR_TILE  = 3'd1,
        OP_LD_TILE  = 3'd2,
        OP_RD_COLL  = 3'd3,
        OP_WR_COLL  = 3'd4,
        OP_RD_ATTR  = 3'd5,
        OP_WR_ATTR  = 3'd6
    } t_op;

    typedef struct packed {
        logic [OP_W-1:0]    opcode;
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
        logic [DATA_W-1:0]  write_value;
    } t_req;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              in_range;
    } t_rsp;

    // decoded location of one request
    typedef struct packed {
        logic               in_map;
        logic [TILE_AW-1:0] tile_idx;
        logic [ATTR_AW-1:0] attr_idx;
        logic [1:0]         field;
    } t_loc;

endpackage

FILE: hdl/tmas_ram.sv
// generic single-port-write, registered-read synchronous ram
module tmas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/tmas_addr.sv
// coordinate check and tile / attribute address decode
module tmas_addr (
    input  logic [tmas_pkg::COORD_W-1:0] i_column,
    input  logic [tmas_pkg::COORD_W-1:0] i_row,
    output tmas_pkg::t_loc               o_loc
);

    localparam int TILE_LIN_W = 2 * tmas_pkg::COORD_W;
    localparam int ATTR_LIN_W = 2 * (tmas_pkg::COORD_W - 2);
    localparam int CMP_W      = tmas_pkg::COORD_W + 1;

    logic [TILE_LIN_W-1:0] tile_lin;
    logic [ATTR_LIN_W-1:0] attr_lin;

    // row-major tile index
    assign tile_lin = TILE_LIN_W'(i_row) * TILE_LIN_W'(tmas_pkg::MAP_WIDTH)
                    + TILE_LIN_W'(i_column);
    // one attribute byte per 4x4 block
    assign attr_lin = ATTR_LIN_W'(i_row[tmas_pkg::COORD_W-1:2])
                    * ATTR_LIN_W'(tmas_pkg::ATTR_STRIDE)
                    + ATTR_LIN_W'(i_column[tmas_pkg::COORD_W-1:2]);

    always_comb begin
        o_loc.in_map   = (CMP_W'(i_column) < CMP_W'(tmas_pkg::MAP_WIDTH))
                      && (CMP_W'(i_row) < CMP_W'(tmas_pkg::MAP_HEIGHT));
        o_loc.tile_idx = tile_lin[tmas_pkg::TILE_AW-1:0];
        o_loc.attr_idx = attr_lin[tmas_pkg::ATTR_AW-1:0];
        o_loc.field    = {i_row[1], i_column[1]};
    end

endmodule

FILE: hdl/tile_map_attribute_store_top.sv
// top level of the tile map attribute store
// result path: a request accepted in idle reads the rams at accept, the execute
//   state merges, and the result and its strobe are registered at its end
// issue: a new request is taken only in idle, not while busy, because of the
//   cell/attr ram read-modify-write (read at accept, write back the cycle after)
// reset: synchronous active-low, clears control only; ram contents are
//   undefined until written, no clearing pass; the receiver cannot stall
module tile_map_attribute_store_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  tmas_pkg::t_req i_req,
    output logic           o_busy,
    output logic           o_strobe,
    output tmas_pkg::t_rsp o_rsp
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;

    tmas_pkg::t_req r_req;
    tmas_pkg::t_loc r_loc;
    tmas_pkg::t_loc in_loc;

    logic           r_strobe;
    tmas_pkg::t_rsp r_rsp, n_rsp;

    logic                          accept;
    logic [tmas_pkg::CELL_W-1:0]   cell_rdata, cell_wdata;
    logic [tmas_pkg::DATA_W-1:0]   attr_rdata, attr_wdata;
    logic                          cell_we, attr_we;
    logic [tmas_pkg::FIELD_W-1:0]  attr_field;
    logic                          solid;

    assign accept = i_start && (r_state == ST_IDLE);
    assign o_busy = (r_state == ST_EXEC);

    // decode the incoming coordinates so the rams are read at accept
    tmas_addr u_addr (
        .i_column (i_req.column),
        .i_row    (i_req.row),
        .o_loc    (in_loc)
    );

    // tile byte and collision bit share one word
    tmas_ram #(
        .WIDTH (tmas_pkg::CELL_W),
        .DEPTH (tmas_pkg::TILE_DEPTH)
    ) u_cell_ram (
        .i_clk   (i_clk),
        .i_we    (cell_we),
        .i_waddr (r_loc.tile_idx),
        .i_wdata (cell_wdata),
        .i_re    (accept),
        .i_raddr (in_loc.tile_idx),
        .o_rdata (cell_rdata)
    );

    tmas_ram #(
        .WIDTH (tmas_pkg::DATA_W),
        .DEPTH (tmas_pkg::ATTR_DEPTH)
    ) u_attr_ram (
        .i_clk   (i_clk),
        .i_we    (attr_we),
        .i_waddr (r_loc.attr_idx),
        .i_wdata (attr_wdata),
        .i_re    (accept),
        .i_raddr (in_loc.attr_idx),
        .o_rdata (attr_rdata)
    );

    // pick the 2-bit field of the attribute byte for this 2x2 group
    always_comb begin
        attr_field = attr_rdata[0 +: tmas_pkg::FIELD_W];
        for (int f = 0; f < tmas_pkg::FIELDS; f++) begin
            if (r_loc.field == 2'(f)) begin
                attr_field = attr_rdata[f*tmas_pkg::FIELD_W +: tmas_pkg::FIELD_W];
            end
        end
    end

    // merged attribute byte for a field write
    always_comb begin
        attr_wdata = attr_rdata;
        for (int f = 0; f < tmas_pkg::FIELDS; f++) begin
            if (r_loc.field == 2'(f)) begin
                attr_wdata[f*tmas_pkg::FIELD_W +: tmas_pkg::FIELD_W] =
                    r_req.write_value[tmas_pkg::FIELD_W-1:0];
            end
        end
    end

    assign solid = (r_req.write_value >= tmas_pkg::DATA_W'(tmas_pkg::SOLID_MIN));

    // modify step: runs in the cycle after accept with ram data in hand
    always_comb begin
        cell_we    = 1'b0;
        attr_we    = 1'b0;
        cell_wdata = cell_rdata;
        n_rsp.read_data = '0;
        n_rsp.in_range  = r_loc.in_map;
        unique case (r_req.opcode)
            tmas_pkg::OP_RD_TILE: begin
                n_rsp.read_data = cell_rdata[tmas_pkg::DATA_W-1:0];
            end
            tmas_pkg::OP_WR_TILE: begin
                cell_we    = 1'b1;
                cell_wdata = {cell_rdata[tmas_pkg::DATA_W], r_req.write_value};
            end
            tmas_pkg::OP_LD_TILE: begin
                cell_we    = 1'b1;
                cell_wdata = {solid, r_req.write_value};
            end
            tmas_pkg::OP_RD_COLL: begin
                n_rsp.read_data =
                    tmas_pkg::DATA_W'(cell_rdata[tmas_pkg::DATA_W]);
            end
            tmas_pkg::OP_WR_COLL: begin
                cell_we    = 1'b1;
                cell_wdata = {r_req.write_value[0],
                              cell_rdata[tmas_pkg::DATA_W-1:0]};
            end
            tmas_pkg::OP_RD_ATTR: begin
                n_rsp.read_data = tmas_pkg::DATA_W'(attr_field);
            end
            tmas_pkg::OP_WR_ATTR: begin
                attr_we = 1'b1;
            end
            default: begin
                // unused opcode: no state change, coordinate check only
            end
        endcase
        // outside the map: reads give zero, writes are dropped
        if (!r_loc.in_map || r_state != ST_EXEC) begin
            cell_we         = 1'b0;
            attr_we         = 1'b0;
            n_rsp.read_data = '0;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= (r_state == ST_EXEC);
        end
    end

    // request hold and result register
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_req;
            r_loc <= in_loc;
        end
        if (r_state == ST_EXEC) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

    // a result strobe always follows an execute cycle
    a_strobe_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state == ST_EXEC))
        else $error("result strobe without an executed request");

    // an accepted request blocks the next one
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (o_busy && !o_strobe))
        else $error("busy not raised after accept");

    // ram writes only for an in-map request being executed
    a_write_guarded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cell_we || attr_we) |-> (r_loc.in_map && r_state == ST_EXEC))
        else $error("ram write outside an in-map execute cycle");

    // a result strobe answers every accepted request
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> ##1 o_strobe)
        else $error("accepted request gave no result");

endmodule
